FILE: hw/rtl/stream_suffix_dictionary_match_assert.svh
// Assertion macros for the stream suffix dictionary matcher.
// Included by the top level; needs no other file.
// Define ASSERT_OFF to compile the checks out.
`ifndef STREAM_SUFFIX_DICTIONARY_MATCH_ASSERT_SVH
`define STREAM_SUFFIX_DICTIONARY_MATCH_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication.
`define SSDM_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ssdm: same-cycle check failed");
// Next-cycle implication.
`define SSDM_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ssdm: next-cycle check failed");
`else
`define SSDM_ASSERT_IMPL(name, clk, rst, ante, cons)
`define SSDM_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

FILE: hw/rtl/ssdm_pkg.sv
// Shared types and constants of the stream suffix dictionary matcher.
// Used by the scan sequencer and the top level; depends on nothing.
package ssdm_pkg;

   localparam int LETTER_W = 5;
   localparam int ERR_W    = 2;

   localparam logic [ERR_W-1:0] ERR_OK       = 2'd0;
   localparam logic [ERR_W-1:0] ERR_FULL     = 2'd1;
   localparam logic [ERR_W-1:0] ERR_TOO_LONG = 2'd2;

   localparam logic MODE_LOAD   = 1'b0;
   localparam logic MODE_STREAM = 1'b1;

   // Status of the scan sequencer as seen by the top level.
   typedef struct packed {
      logic busy;
      logic done;
      logic match;
   } scan_stat_type;

endpackage

FILE: hw/rtl/ssdm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used for the word letters, word lengths and stream history; no dependencies.
module ssdm_ram #(
   parameter int WIDTH = 5,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                            wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                            rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: hw/rtl/ssdm_scan.sv
// Scan sequencer: walks the stored words one at a time and compares each,
// newest letter first, against the history with one shared comparator.
// Depends on ssdm_pkg; drives the read ports of the three RAMs.
module ssdm_scan
   import ssdm_pkg::*;
#(
   parameter int MAX_WORDS = 32,
   parameter int MAX_LEN   = 16
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              go,
   input  logic [$clog2(MAX_WORDS+1)-1:0]                    word_count,
   input  logic [$clog2(MAX_LEN+1)-1:0]                      hist_fill,
   input  logic [((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0]  hist_newest,
   input  logic [$clog2(MAX_LEN+1)-1:0]                      len_rdata,
   input  logic [LETTER_W-1:0]                               pat_rdata,
   input  logic [LETTER_W-1:0]                               hist_rdata,
   output logic [((MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1)-1:0] len_raddr,
   output logic [((MAX_WORDS * MAX_LEN > 1) ?
                  $clog2(MAX_WORDS * MAX_LEN) : 1)-1:0]      pat_raddr,
   output logic [((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0]  hist_raddr,
   output scan_stat_type                                     stat
);

   localparam int CNT_W = $clog2(MAX_WORDS + 1);
   localparam int W_IDX = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
   localparam int LEN_W = $clog2(MAX_LEN + 1);
   localparam int P_IDX = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int PA_W  = (MAX_WORDS * MAX_LEN > 1) ? $clog2(MAX_WORDS * MAX_LEN) : 1;

   typedef enum logic [4:0] {
      S_IDLE    = 5'b00001,
      S_LEN_RD  = 5'b00010,
      S_LEN_CHK = 5'b00100,
      S_CMP_RD  = 5'b01000,
      S_CMP_CHK = 5'b10000
   } scan_state_type;

   scan_state_type   state_ff, state_in;
   logic [W_IDX-1:0] word_ff, word_in;
   logic [PA_W-1:0]  base_ff, base_in;
   logic [P_IDX-1:0] pos_ff, pos_in;
   logic [P_IDX-1:0] hptr_ff, hptr_in;
   logic             last_word;

   // The current word is the last stored one.
   assign last_word = (CNT_W'(word_ff) + CNT_W'(1)) == word_count;

   assign len_raddr  = word_ff;
   assign pat_raddr  = base_ff + PA_W'(pos_ff);
   assign hist_raddr = hptr_ff;

   always_comb begin
      state_in   = state_ff;
      word_in    = word_ff;
      base_in    = base_ff;
      pos_in     = pos_ff;
      hptr_in    = hptr_ff;
      stat.busy  = (state_ff != S_IDLE);
      stat.done  = 1'b0;
      stat.match = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (go) begin
               if (word_count == '0) begin
                  stat.done = 1'b1;
               end else begin
                  word_in  = '0;
                  base_in  = '0;
                  state_in = S_LEN_RD;
               end
            end
         end
         S_LEN_RD: begin
            state_in = S_LEN_CHK;
         end
         S_LEN_CHK: begin
            if (len_rdata <= hist_fill) begin
               pos_in   = P_IDX'(len_rdata - LEN_W'(1));
               hptr_in  = hist_newest;
               state_in = S_CMP_RD;
            end else if (last_word) begin
               stat.done = 1'b1;
               state_in  = S_IDLE;
            end else begin
               word_in  = word_ff + W_IDX'(1);
               base_in  = base_ff + PA_W'(MAX_LEN);
               state_in = S_LEN_RD;
            end
         end
         S_CMP_RD: begin
            state_in = S_CMP_CHK;
         end
         S_CMP_CHK: begin
            if (pat_rdata != hist_rdata) begin
               if (last_word) begin
                  stat.done = 1'b1;
                  state_in  = S_IDLE;
               end else begin
                  word_in  = word_ff + W_IDX'(1);
                  base_in  = base_ff + PA_W'(MAX_LEN);
                  state_in = S_LEN_RD;
               end
            end else if (pos_ff == '0) begin
               stat.done  = 1'b1;
               stat.match = 1'b1;
               state_in   = S_IDLE;
            end else begin
               pos_in   = pos_ff - P_IDX'(1);
               hptr_in  = (hptr_ff == '0) ? P_IDX'(MAX_LEN - 1) : hptr_ff - P_IDX'(1);
               state_in = S_CMP_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      base_ff <= base_in;
      pos_ff  <= pos_in;
      hptr_ff <= hptr_in;
   end

endmodule

FILE: hw/rtl/stream_suffix_dictionary_match.sv
// Stream suffix dictionary matcher, top level.
// Depends on ssdm_pkg, ssdm_ram, ssdm_scan and the assertion macro header.
//
// Each item is either a letter of a dictionary word being loaded (req_mode
// low, req_word_end marking the last letter) or a stream letter (req_mode
// high). Every item gives exactly one result: for a load letter, rsp_error
// reports a word dropped because the dictionary was full or the word longer
// than MAX_LEN; for a stream letter, rsp_match tells whether some stored word
// equals the newest letters of the stream. An item is taken when start is
// high and busy is low, and its result appears for one cycle, marked by
// rsp_valid, which the receiver cannot hold off. A load item never raises
// busy. A stream item with an empty dictionary does not raise busy either;
// otherwise the scan visits the stored words one after another through a
// single read port on the letter and history RAMs and one letter
// comparator, and each letter pair passes through the registered RAM
// reads before it is compared. A word is compared from its last letter
// backward against the history, newest first, and the scan stops at the
// first full match. busy stays high while the scan runs; the result follows
// the cycle after the scan ends, and a new item may be offered in that same
// cycle. No clearing pass is needed after reset.
`include "stream_suffix_dictionary_match_assert.svh"

module stream_suffix_dictionary_match
   import ssdm_pkg::*;
#(
   parameter int MAX_WORDS = 32,
   parameter int MAX_LEN   = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_mode,
   input  logic [LETTER_W-1:0] req_letter,
   input  logic                req_word_end,
   output logic                rsp_valid,
   output logic                rsp_match,
   output logic [ERR_W-1:0]    rsp_error
);

   localparam int CNT_W     = $clog2(MAX_WORDS + 1);
   localparam int W_IDX     = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
   localparam int LEN_W     = $clog2(MAX_LEN + 1);
   localparam int P_IDX     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int PAT_DEPTH = MAX_WORDS * MAX_LEN;
   localparam int PA_W      = (PAT_DEPTH > 1) ? $clog2(PAT_DEPTH) : 1;

   // Dictionary loading state.
   logic [CNT_W-1:0] word_count_ff, word_count_in;
   logic [LEN_W-1:0] load_len_ff, load_len_in;
   logic             too_long_ff, too_long_in;
   logic [PA_W-1:0]  word_base_ff, word_base_in;

   // History ring: head is the next slot to write, newest the last written.
   logic [P_IDX-1:0] hist_head_ff, hist_head_in;
   logic [P_IDX-1:0] hist_newest_ff, hist_newest_in;
   logic [LEN_W-1:0] hist_fill_ff, hist_fill_in;

   // Result register.
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_match_ff, rsp_match_in;
   logic [ERR_W-1:0] rsp_error_ff, rsp_error_in;

   logic             accept, load_acc, strm_acc;
   logic             room, too_long_now, dict_full;
   logic [LEN_W-1:0] load_len_next;
   logic [ERR_W-1:0] load_err;

   logic                pat_we;
   logic [PA_W-1:0]     pat_waddr, pat_raddr;
   logic [LETTER_W-1:0] pat_rdata;
   logic                len_we;
   logic [W_IDX-1:0]    len_waddr, len_raddr;
   logic [LEN_W-1:0]    len_wdata, len_rdata;
   logic                hist_we;
   logic [P_IDX-1:0]    hist_raddr;
   logic [LETTER_W-1:0] hist_rdata;

   scan_stat_type scan_stat;

   assign busy     = scan_stat.busy;
   assign accept   = start & ~busy;
   assign load_acc = accept & (req_mode == MODE_LOAD);
   assign strm_acc = accept & (req_mode == MODE_STREAM);

   // Letters past MAX_LEN are not stored; they only mark the word too long.
   assign room          = load_len_ff < LEN_W'(MAX_LEN);
   assign too_long_now  = too_long_ff | ~room;
   assign dict_full     = word_count_ff >= CNT_W'(MAX_WORDS);
   assign load_len_next = room ? load_len_ff + LEN_W'(1) : load_len_ff;

   // Too long wins over full when both apply.
   always_comb begin
      if (too_long_now) begin
         load_err = ERR_TOO_LONG;
      end else if (dict_full) begin
         load_err = ERR_FULL;
      end else begin
         load_err = ERR_OK;
      end
   end

   assign pat_we    = load_acc & room & ~dict_full;
   assign pat_waddr = word_base_ff + PA_W'(load_len_ff);

   assign len_we    = load_acc & req_word_end & (load_err == ERR_OK);
   assign len_waddr = word_count_ff[W_IDX-1:0];
   assign len_wdata = load_len_next;

   assign hist_we = strm_acc;

   always_comb begin
      word_count_in  = word_count_ff;
      load_len_in    = load_len_ff;
      too_long_in    = too_long_ff;
      word_base_in   = word_base_ff;
      hist_head_in   = hist_head_ff;
      hist_newest_in = hist_newest_ff;
      hist_fill_in   = hist_fill_ff;

      if (load_acc) begin
         if (req_word_end) begin
            load_len_in = '0;
            too_long_in = 1'b0;
            if (load_err == ERR_OK) begin
               word_count_in = word_count_ff + CNT_W'(1);
               word_base_in  = word_base_ff + PA_W'(MAX_LEN);
            end
         end else begin
            load_len_in = load_len_next;
            too_long_in = too_long_now;
         end
      end

      if (strm_acc) begin
         hist_newest_in = hist_head_ff;
         hist_head_in   = (hist_head_ff == P_IDX'(MAX_LEN - 1)) ? '0
                                                                 : hist_head_ff + P_IDX'(1);
         if (hist_fill_ff < LEN_W'(MAX_LEN)) begin
            hist_fill_in = hist_fill_ff + LEN_W'(1);
         end
      end
   end

   // A load item answers at once; a stream item answers when the scan ends.
   // A dropped word is only reported on the letter that ends it.
   assign rsp_valid_in = load_acc | scan_stat.done;
   assign rsp_match_in = ~load_acc & scan_stat.match;
   assign rsp_error_in = (load_acc & req_word_end) ? load_err : ERR_OK;

   always_ff @(posedge clock) begin
      if (reset) begin
         word_count_ff  <= '0;
         load_len_ff    <= '0;
         too_long_ff    <= 1'b0;
         word_base_ff   <= '0;
         hist_head_ff   <= '0;
         hist_newest_ff <= '0;
         hist_fill_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         word_count_ff  <= word_count_in;
         load_len_ff    <= load_len_in;
         too_long_ff    <= too_long_in;
         word_base_ff   <= word_base_in;
         hist_head_ff   <= hist_head_in;
         hist_newest_ff <= hist_newest_in;
         hist_fill_ff   <= hist_fill_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_valid_in) begin
         rsp_match_ff <= rsp_match_in;
         rsp_error_ff <= rsp_error_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_match = rsp_match_ff;
   assign rsp_error = rsp_error_ff;

   // Word letters, each word in forward order in a row of MAX_LEN slots.
   ssdm_ram #(
      .WIDTH (LETTER_W),
      .DEPTH (PAT_DEPTH)
   ) u_pat_ram (
      .clock (clock),
      .we    (pat_we),
      .waddr (pat_waddr),
      .wdata (req_letter),
      .raddr (pat_raddr),
      .rdata (pat_rdata)
   );

   // Length of each stored word.
   ssdm_ram #(
      .WIDTH (LEN_W),
      .DEPTH (MAX_WORDS)
   ) u_len_ram (
      .clock (clock),
      .we    (len_we),
      .waddr (len_waddr),
      .wdata (len_wdata),
      .raddr (len_raddr),
      .rdata (len_rdata)
   );

   // Newest MAX_LEN stream letters as a ring.
   ssdm_ram #(
      .WIDTH (LETTER_W),
      .DEPTH (MAX_LEN)
   ) u_hist_ram (
      .clock (clock),
      .we    (hist_we),
      .waddr (hist_head_ff),
      .wdata (req_letter),
      .raddr (hist_raddr),
      .rdata (hist_rdata)
   );

   ssdm_scan #(
      .MAX_WORDS (MAX_WORDS),
      .MAX_LEN   (MAX_LEN)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .go          (strm_acc),
      .word_count  (word_count_ff),
      .hist_fill   (hist_fill_ff),
      .hist_newest (hist_newest_ff),
      .len_rdata   (len_rdata),
      .pat_rdata   (pat_rdata),
      .hist_rdata  (hist_rdata),
      .len_raddr   (len_raddr),
      .pat_raddr   (pat_raddr),
      .hist_raddr  (hist_raddr),
      .stat        (scan_stat)
   );

   // A load item always answers in the next cycle.
   `SSDM_ASSERT_NEXT(a_load_answers, clock, reset, load_acc, rsp_valid)
   // A result is never shown while a scan is still running.
   `SSDM_ASSERT_IMPL(a_rsp_not_busy, clock, reset, rsp_valid, !busy)
   // A match only comes from a stream item, which never carries an error.
   `SSDM_ASSERT_IMPL(a_match_no_err, clock, reset, rsp_valid && rsp_match,
                     rsp_error == ERR_OK)
   // The history never counts more letters than it keeps.
   `SSDM_ASSERT_IMPL(a_fill_bound, clock, reset, 1'b1,
                     hist_fill_ff <= LEN_W'(MAX_LEN))

endmodule
